// ===== src/dbrt_pkg.sv =====
// ----------------------------------------------------------------------------
// dbrt_pkg
// Shared types and constants of the distance banded relay throttle.
// ----------------------------------------------------------------------------
package dbrt_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int SKIP_BITS_DEF  = 8;

    localparam logic [63:0] HASH_K1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] HASH_K2 = 64'h94d049bb133111eb;

    localparam logic [15:0] NEAR_RESET     = 16'd1024;
    localparam int          MAX_SKIP_RESET = 4;

    typedef enum logic [1:0] {
        CFG_ENABLE   = 2'd0,
        CFG_NEAR     = 2'd1,
        CFG_PRESSURE = 2'd2,
        CFG_MAX_SKIP = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic        enable;
        logic [15:0] near;
        logic [7:0]  pressure;
    } t_cfg;

endpackage

// ===== src/distance_banded_relay_throttle_top.sv =====
// ----------------------------------------------------------------------------
// distance_banded_relay_throttle_top
// Decides per relay edge whether it is sent this tick, by distance band.
// ----------------------------------------------------------------------------
// path from word accept to o_out_valid: 7 front stages, 64 remainder cells
//   and one output register; each remainder cell handles one hash and tick bit
// throughput: one word per cycle while the skid entry is free
// a two-entry output buffer keeps the pipeline moving while one result waits
// reset: synchronous active low, clears valid bits and loads register defaults
module distance_banded_relay_throttle_top #(
    parameter int COORD_BITS = dbrt_pkg::COORD_BITS_DEF,
    parameter int SKIP_BITS  = dbrt_pkg::SKIP_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [COORD_BITS-1:0] i_sender_x,
    input  logic signed [COORD_BITS-1:0] i_sender_y,
    input  logic signed [COORD_BITS-1:0] i_sender_z,
    input  logic signed [COORD_BITS-1:0] i_target_x,
    input  logic signed [COORD_BITS-1:0] i_target_y,
    input  logic signed [COORD_BITS-1:0] i_target_z,
    input  logic [31:0]                  i_sender_id,
    input  logic [15:0]                  i_recipient_id,
    input  logic [63:0]                  i_tick_index,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_relay_now,
    output logic [7:0]                   o_skip_factor,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_index,
    input  logic [((SKIP_BITS > 16) ? SKIP_BITS : 16)-1:0] i_cfg_data
);

    localparam int SW8   = (SKIP_BITS > 8) ? SKIP_BITS : 8;

    dbrt_pkg::t_cfg       r_cfg;
    logic [SKIP_BITS-1:0] r_max_skip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable   <= 1'b0;
            r_cfg.near     <= dbrt_pkg::NEAR_RESET;
            r_cfg.pressure <= 8'd0;
            r_max_skip     <= SKIP_BITS'(dbrt_pkg::MAX_SKIP_RESET);
        end else if (i_cfg_we) begin
            unique case (dbrt_pkg::t_cfg_idx'(i_cfg_index))
                dbrt_pkg::CFG_ENABLE:   r_cfg.enable   <= i_cfg_data[0];
                dbrt_pkg::CFG_NEAR:     r_cfg.near     <= i_cfg_data[15:0];
                dbrt_pkg::CFG_PRESSURE: r_cfg.pressure <= i_cfg_data[7:0];
                dbrt_pkg::CFG_MAX_SKIP: r_max_skip     <= i_cfg_data[SKIP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advances whenever the skid entry is free
    logic r_skid_vld;
    logic en;
    assign en         = !r_skid_vld;
    assign o_in_ready = en;

    logic                 c_vld   [65];
    logic [SKIP_BITS-1:0] c_skip  [65];
    logic [SKIP_BITS-1:0] c_rem_h [65];
    logic [SKIP_BITS-1:0] c_rem_t [65];
    logic [63:0]          c_hash  [65];
    logic [63:0]          c_tick  [65];

    dbrt_front #(
        .COORD_BITS(COORD_BITS),
        .SKIP_BITS (SKIP_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (i_in_valid),
        .i_sender_x    (i_sender_x),
        .i_sender_y    (i_sender_y),
        .i_sender_z    (i_sender_z),
        .i_target_x    (i_target_x),
        .i_target_y    (i_target_y),
        .i_target_z    (i_target_z),
        .i_sender_id   (i_sender_id),
        .i_recipient_id(i_recipient_id),
        .i_tick_index  (i_tick_index),
        .i_cfg         (r_cfg),
        .i_max_skip    (r_max_skip),
        .o_valid       (c_vld[0]),
        .o_skip        (c_skip[0]),
        .o_hash        (c_hash[0]),
        .o_tick        (c_tick[0])
    );

    assign c_rem_h[0] = '0;
    assign c_rem_t[0] = '0;

    for (genvar k = 0; k < 64; k++) begin : g_cell
        dbrt_mod_cell #(
            .SKIP_BITS(SKIP_BITS),
            .BIT_IDX  (63 - k)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_valid(c_vld[k]),
            .i_skip (c_skip[k]),
            .i_rem_h(c_rem_h[k]),
            .i_rem_t(c_rem_t[k]),
            .i_hash (c_hash[k]),
            .i_tick (c_tick[k]),
            .o_valid(c_vld[k+1]),
            .o_skip (c_skip[k+1]),
            .o_rem_h(c_rem_h[k+1]),
            .o_rem_t(c_rem_t[k+1]),
            .o_hash (c_hash[k+1]),
            .o_tick (c_tick[k+1])
        );
    end

    // result word at the end of the chain
    logic [SW8-1:0] p_skip_ext;
    logic           p_relay;
    assign p_skip_ext = SW8'(c_skip[64]);
    assign p_relay    = (c_rem_h[64] == c_rem_t[64]);

    logic       r_out_vld, r_out_relay, r_skid_relay;
    logic [7:0] r_out_skip, r_skid_skip;
    logic       take;
    assign take = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (r_skid_vld) begin
                if (i_out_ready) begin
                    r_out_vld  <= 1'b1;
                    r_skid_vld <= 1'b0;
                end
            end else if (take) begin
                r_out_vld <= c_vld[64];
            end else if (c_vld[64]) begin
                r_skid_vld <= 1'b1;
            end
        end
        if (r_skid_vld) begin
            if (i_out_ready) begin
                r_out_relay <= r_skid_relay;
                r_out_skip  <= r_skid_skip;
            end
        end else if (take) begin
            r_out_relay <= p_relay;
            r_out_skip  <= p_skip_ext[7:0];
        end else begin
            r_skid_relay <= p_relay;
            r_skid_skip  <= p_skip_ext[7:0];
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_relay_now   = r_out_relay;
    assign o_skip_factor = r_out_skip;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid word held with empty output register");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld && !i_out_ready |=> r_skid_vld && r_out_vld)
        else $error("skid word lost while output stalled");

    a_unity_relays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_skip_factor == 8'd1) && (SKIP_BITS <= 8) |-> o_relay_now)
        else $error("skip factor one but word throttled");

endmodule

// ===== src/dbrt_front.sv =====
// ----------------------------------------------------------------------------
// dbrt_front
// Squared distance, band and skip factor, and the pipelined pair hash.
// ----------------------------------------------------------------------------
module dbrt_front #(
    parameter int COORD_BITS = dbrt_pkg::COORD_BITS_DEF,
    parameter int SKIP_BITS  = dbrt_pkg::SKIP_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_sender_x,
    input  logic signed [COORD_BITS-1:0] i_sender_y,
    input  logic signed [COORD_BITS-1:0] i_sender_z,
    input  logic signed [COORD_BITS-1:0] i_target_x,
    input  logic signed [COORD_BITS-1:0] i_target_y,
    input  logic signed [COORD_BITS-1:0] i_target_z,
    input  logic [31:0]                  i_sender_id,
    input  logic [15:0]                  i_recipient_id,
    input  logic [63:0]                  i_tick_index,
    input  dbrt_pkg::t_cfg               i_cfg,
    input  logic [SKIP_BITS-1:0]         i_max_skip,
    output logic                         o_valid,
    output logic [SKIP_BITS-1:0]         o_skip,
    output logic [63:0]                  o_hash,
    output logic [63:0]                  o_tick
);

    localparam int DW = COORD_BITS + 1;
    localparam int FW = (SKIP_BITS > 10) ? SKIP_BITS : 10;

    // stage 1
    logic signed [DW-1:0] d_x, d_y, d_z;
    logic [DW-1:0]        m_x, m_y, m_z;
    logic [47:0]          h0;
    logic [32:0]          r1_mag [3];
    logic [47:0]          r1_h;
    logic [63:0]          r1_tick;
    logic                 r1_act, r1_vld;
    logic [31:0]          r1_thr;

    always_comb begin
        d_x = {i_sender_x[COORD_BITS-1], i_sender_x} - {i_target_x[COORD_BITS-1], i_target_x};
        d_y = {i_sender_y[COORD_BITS-1], i_sender_y} - {i_target_y[COORD_BITS-1], i_target_y};
        d_z = {i_sender_z[COORD_BITS-1], i_sender_z} - {i_target_z[COORD_BITS-1], i_target_z};
        m_x = d_x[DW-1] ? DW'(-d_x) : DW'(d_x);
        m_y = d_y[DW-1] ? DW'(-d_y) : DW'(d_y);
        m_z = d_z[DW-1] ? DW'(-d_z) : DW'(d_z);
        h0  = {i_sender_id, i_recipient_id};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
        end
        if (i_en) begin
            r1_mag[0] <= 33'(m_x);
            r1_mag[1] <= 33'(m_y);
            r1_mag[2] <= 33'(m_z);
            r1_h      <= h0 ^ (h0 >> 30);
            r1_tick   <= i_tick_index;
            r1_act    <= i_cfg.enable && (i_cfg.pressure != 8'd0);
            r1_thr    <= 32'(i_cfg.near) * 32'(i_cfg.near);
        end
    end

    // stage 2: axis squares and first hash product terms
    logic [63:0] n2_sq [3];
    logic [63:0] n2_pp0, n2_pp1, n2_pp2;
    logic [63:0] r2_sq [3];
    logic [63:0] r2_pp0;
    logic [31:0] r2_pp1, r2_pp2;
    logic [63:0] r2_tick;
    logic        r2_act, r2_vld;
    logic [31:0] r2_thr;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n2_sq[a] = r1_mag[a][32] ? '1 : 64'(r1_mag[a][31:0]) * 64'(r1_mag[a][31:0]);
        end
        n2_pp0 = 64'(r1_h[31:0]) * 64'(dbrt_pkg::HASH_K1[31:0]);
        n2_pp1 = 64'(r1_h[31:0]) * 64'(dbrt_pkg::HASH_K1[63:32]);
        n2_pp2 = 64'(r1_h[47:32]) * 64'(dbrt_pkg::HASH_K1[31:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
        if (i_en) begin
            r2_sq   <= n2_sq;
            r2_pp0  <= n2_pp0;
            r2_pp1  <= n2_pp1[31:0];
            r2_pp2  <= n2_pp2[31:0];
            r2_tick <= r1_tick;
            r2_act  <= r1_act;
            r2_thr  <= r1_thr;
        end
    end

    // stage 3: saturating distance sum, first hash product
    logic [65:0] n3_sum;
    logic [31:0] n3_cross;
    logic [63:0] r3_sq, r3_m1, r3_tick;
    logic        r3_act, r3_vld;
    logic [31:0] r3_thr;

    always_comb begin
        n3_sum   = 66'(r2_sq[0]) + 66'(r2_sq[1]) + 66'(r2_sq[2]);
        n3_cross = r2_pp1 + r2_pp2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld <= r2_vld;
        end
        if (i_en) begin
            r3_sq   <= (n3_sum[65:64] != 2'd0) ? '1 : n3_sum[63:0];
            r3_m1   <= r2_pp0 + {n3_cross, 32'd0};
            r3_tick <= r2_tick;
            r3_act  <= r2_act;
            r3_thr  <= r2_thr;
        end
    end

    // stage 4: band and capped skip factor
    logic [1:0]           n4_band;
    logic [FW-1:0]        n4_fac, n4_cap;
    logic [SKIP_BITS-1:0] n4_skip;
    logic [SKIP_BITS-1:0] r4_skip;
    logic [63:0]          r4_h2, r4_tick;
    logic                 r4_vld;

    always_comb begin
        n4_band = 2'd1;
        if (r3_sq > 64'({r3_thr, 2'b00})) n4_band = 2'd2;
        if (r3_sq > 64'({r3_thr, 4'b0000})) n4_band = 2'd3;
        n4_fac = FW'(10'(i_cfg.pressure) * 10'(n4_band) + 10'd1);
        n4_cap = (i_max_skip == '0) ? FW'(1) : FW'(i_max_skip);
        if (!r3_act || !(r3_sq > 64'(r3_thr))) begin
            n4_skip = SKIP_BITS'(1);
        end else if (n4_fac > n4_cap) begin
            n4_skip = n4_cap[SKIP_BITS-1:0];
        end else begin
            n4_skip = n4_fac[SKIP_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r4_vld <= r3_vld;
        end
        if (i_en) begin
            r4_skip <= n4_skip;
            r4_h2   <= r3_m1 ^ (r3_m1 >> 27);
            r4_tick <= r3_tick;
        end
    end

    // stage 5: second hash product terms
    logic [63:0]          n5_pp0, n5_pp1, n5_pp2;
    logic [63:0]          r5_pp0, r5_tick;
    logic [31:0]          r5_pp1, r5_pp2;
    logic [SKIP_BITS-1:0] r5_skip;
    logic                 r5_vld;

    always_comb begin
        n5_pp0 = 64'(r4_h2[31:0]) * 64'(dbrt_pkg::HASH_K2[31:0]);
        n5_pp1 = 64'(r4_h2[31:0]) * 64'(dbrt_pkg::HASH_K2[63:32]);
        n5_pp2 = 64'(r4_h2[63:32]) * 64'(dbrt_pkg::HASH_K2[31:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r5_vld <= r4_vld;
        end
        if (i_en) begin
            r5_pp0  <= n5_pp0;
            r5_pp1  <= n5_pp1[31:0];
            r5_pp2  <= n5_pp2[31:0];
            r5_skip <= r4_skip;
            r5_tick <= r4_tick;
        end
    end

    // stage 6 and 7: second product and final mix
    logic [31:0]          n6_cross;
    logic [63:0]          r6_m2, r6_tick;
    logic [SKIP_BITS-1:0] r6_skip;
    logic                 r6_vld;
    logic [63:0]          r7_h3, r7_tick;
    logic [SKIP_BITS-1:0] r7_skip;
    logic                 r7_vld;

    assign n6_cross = r5_pp1 + r5_pp2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
        end else if (i_en) begin
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
        end
        if (i_en) begin
            r6_m2   <= r5_pp0 + {n6_cross, 32'd0};
            r6_skip <= r5_skip;
            r6_tick <= r5_tick;
            r7_h3   <= r6_m2 ^ (r6_m2 >> 31);
            r7_skip <= r6_skip;
            r7_tick <= r6_tick;
        end
    end

    assign o_valid = r7_vld;
    assign o_skip  = r7_skip;
    assign o_hash  = r7_h3;
    assign o_tick  = r7_tick;

endmodule

// ===== src/dbrt_mod_cell.sv =====
// ----------------------------------------------------------------------------
// dbrt_mod_cell
// One restoring remainder step for the hash and the tick, one bit per cell.
// ----------------------------------------------------------------------------
module dbrt_mod_cell #(
    parameter int SKIP_BITS = dbrt_pkg::SKIP_BITS_DEF,
    parameter int BIT_IDX   = 63
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [SKIP_BITS-1:0] i_skip,
    input  logic [SKIP_BITS-1:0] i_rem_h,
    input  logic [SKIP_BITS-1:0] i_rem_t,
    input  logic [63:0]          i_hash,
    input  logic [63:0]          i_tick,
    output logic                 o_valid,
    output logic [SKIP_BITS-1:0] o_skip,
    output logic [SKIP_BITS-1:0] o_rem_h,
    output logic [SKIP_BITS-1:0] o_rem_t,
    output logic [63:0]          o_hash,
    output logic [63:0]          o_tick
);

    logic [SKIP_BITS:0]   cand_h, cand_t, div;
    logic [SKIP_BITS:0]   s_h, s_t;
    logic                 r_vld;
    logic [SKIP_BITS-1:0] r_skip, r_rem_h, r_rem_t;
    logic [63:0]          r_hash, r_tick;

    always_comb begin
        div    = {1'b0, i_skip};
        cand_h = {i_rem_h, i_hash[BIT_IDX]};
        cand_t = {i_rem_t, i_tick[BIT_IDX]};
        s_h    = (cand_h >= div) ? cand_h - div : cand_h;
        s_t    = (cand_t >= div) ? cand_t - div : cand_t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_valid;
        end
        if (i_en) begin
            r_skip  <= i_skip;
            r_rem_h <= s_h[SKIP_BITS-1:0];
            r_rem_t <= s_t[SKIP_BITS-1:0];
            r_hash  <= i_hash;
            r_tick  <= i_tick;
        end
    end

    assign o_valid = r_vld;
    assign o_skip  = r_skip;
    assign o_rem_h = r_rem_h;
    assign o_rem_t = r_rem_t;
    assign o_hash  = r_hash;
    assign o_tick  = r_tick;

endmodule

// ===== tb/distance_banded_relay_throttle_top_tb.sv =====
// ----------------------------------------------------------------------------
// distance_banded_relay_throttle_top_tb
// Streams relay edges through the throttle under several register settings
// and handshake pressure, predicts band, skip factor and relay phase per
// edge, and compares every result word against the oldest prediction.
// ----------------------------------------------------------------------------
module distance_banded_relay_throttle_top_tb;

    localparam int CW      = 24;
    localparam int LATENCY = 72;

    typedef struct packed {
        logic       relay;
        logic [7:0] skip;
    } t_verdict;

    typedef struct {
        logic signed [CW-1:0] sx, sy, sz, tx, ty, tz;
        logic [31:0]          sid;
        logic [15:0]          rid;
        logic [63:0]          tick;
    } t_edge;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic signed [CW-1:0] i_sender_x, i_sender_y, i_sender_z;
    logic signed [CW-1:0] i_target_x, i_target_y, i_target_z;
    logic [31:0]          i_sender_id;
    logic [15:0]          i_recipient_id;
    logic [63:0]          i_tick_index;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_relay_now;
    logic [7:0]           o_skip_factor;
    logic                 i_cfg_we;
    logic [1:0]           i_cfg_index;
    logic [15:0]          i_cfg_data;

    // shadow registers
    logic        thr_enable;
    logic [15:0] thr_near;
    logic [7:0]  thr_pressure;
    logic [7:0]  thr_max_skip;

    t_verdict verdict_q[$];
    int       errors;
    int       send_idle_pct;
    int       recv_stall_pct;

    distance_banded_relay_throttle_top dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("distance_banded_relay_throttle_top regression: fail");
        $finish;
    end

    function automatic logic [63:0] axis_sq(logic signed [CW-1:0] a, logic signed [CW-1:0] b);
        logic signed [63:0] d;
        d = 64'(a) - 64'(b);
        if (d < 0) d = -d;
        return d * d;
    endfunction

    function automatic logic [63:0] mix_pair(logic [31:0] sid, logic [15:0] rid);
        logic [63:0] h;
        h = {16'd0, sid, rid};
        h = h ^ (h >> 30);
        h = h * dbrt_pkg::HASH_K1;
        h = h ^ (h >> 27);
        h = h * dbrt_pkg::HASH_K2;
        h = h ^ (h >> 31);
        return h;
    endfunction

    function automatic t_verdict throttle_decision(t_edge e);
        t_verdict    v;
        logic [63:0] dist_sq, near_sq, skip, cap, band;
        skip = 64'd1;
        v.relay = 1'b1;
        if (thr_enable && thr_pressure != 0) begin
            dist_sq = axis_sq(e.sx, e.tx) + axis_sq(e.sy, e.ty) + axis_sq(e.sz, e.tz);
            near_sq = 64'(thr_near) * 64'(thr_near);
            if (dist_sq > near_sq) begin
                cap  = (thr_max_skip == 0) ? 64'd1 : 64'(thr_max_skip);
                band = 64'd1;
                if (dist_sq > near_sq * 4) band = 64'd2;
                if (dist_sq > near_sq * 16) band = 64'd3;
                skip = 64'(thr_pressure) * band + 1;
                if (skip > cap) skip = cap;
            end
        end
        if (skip > 1)
            v.relay = ((e.tick % skip) == (mix_pair(e.sid, e.rid) % skip));
        v.skip = skip[7:0];
        return v;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected word relay=%0b skip=%0d", $time,
                         o_relay_now, o_skip_factor);
                errors++;
            end else begin
                want = verdict_q.pop_front();
                if (o_relay_now !== want.relay) begin
                    $display("%0t: relay_now expected %0b actual %0b", $time,
                             want.relay, o_relay_now);
                    errors++;
                end
                if (o_skip_factor !== want.skip) begin
                    $display("%0t: skip_factor expected %0d actual %0d", $time,
                             want.skip, o_skip_factor);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_edge(t_edge e);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_sender_x     = e.sx;
        i_sender_y     = e.sy;
        i_sender_z     = e.sz;
        i_target_x     = e.tx;
        i_target_y     = e.ty;
        i_target_z     = e.tz;
        i_sender_id    = e.sid;
        i_recipient_id = e.rid;
        i_tick_index   = e.tick;
        forever begin
            @(posedge i_clk);
            if (o_in_ready) break;
            @(negedge i_clk);
        end
        verdict_q.insert(verdict_q.size(), throttle_decision(e));
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic drain;
        while (verdict_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 8) @(negedge i_clk);
    endtask

    task automatic write_reg(dbrt_pkg::t_cfg_idx idx, logic [15:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            dbrt_pkg::CFG_ENABLE:   thr_enable   = val[0];
            dbrt_pkg::CFG_NEAR:     thr_near     = val;
            dbrt_pkg::CFG_PRESSURE: thr_pressure = val[7:0];
            dbrt_pkg::CFG_MAX_SKIP: thr_max_skip = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(logic en, logic [15:0] nr, logic [7:0] pr, logic [7:0] ms);
        drain();
        write_reg(dbrt_pkg::CFG_ENABLE, {15'($urandom_range(32767)), en});
        write_reg(dbrt_pkg::CFG_NEAR, nr);
        write_reg(dbrt_pkg::CFG_PRESSURE, {8'($urandom_range(255)), pr});
        write_reg(dbrt_pkg::CFG_MAX_SKIP, {8'($urandom_range(255)), ms});
    endtask

    function automatic t_edge make_edge(logic signed [CW-1:0] dx, logic signed [CW-1:0] dy,
                                        logic signed [CW-1:0] dz);
        t_edge e;
        e.sx   = CW'($urandom);
        e.sy   = CW'($urandom);
        e.sz   = CW'($urandom);
        e.tx   = e.sx + dx;
        e.ty   = e.sy + dy;
        e.tz   = e.sz + dz;
        e.sid  = $urandom;
        e.rid  = 16'($urandom);
        e.tick = {$urandom, $urandom};
        return e;
    endfunction

    // delta scaled around the near radius so all bands get hit
    function automatic logic signed [CW-1:0] band_delta();
        int   lim;
        int   pick;
        pick = $urandom_range(5);
        case (pick)
            0: lim = thr_near / 2;
            1: lim = thr_near;
            2: lim = thr_near * 2;
            3: lim = thr_near * 4;
            4: lim = thr_near * 8;
            default: return CW'($urandom);
        endcase
        return CW'($signed($urandom_range(2 * lim)) - lim);
    endfunction

    task automatic test_reset_defaults;
        t_edge e;
        e = make_edge(CW'(5000), 0, 0);
        send_edge(e);
        e.sx = {1'b0, {(CW-1){1'b1}}};
        e.tx = {1'b1, {(CW-1){1'b0}}};
        send_edge(e);
    endtask

    task automatic test_directed_bands;
        t_edge e;
        set_regs(1'b1, 16'd100, 8'd1, 8'd255);
        e = make_edge(CW'(100), 0, 0); send_edge(e);   // on the near edge
        e = make_edge(CW'(101), 0, 0); send_edge(e);   // band one
        e = make_edge(CW'(201), 0, 0); send_edge(e);   // band two
        e = make_edge(CW'(401), 0, 0); send_edge(e);   // band three
        e = make_edge(0, 0, 0);        send_edge(e);
        // extreme positions on all axes
        e.sx = {1'b0, {(CW-1){1'b1}}}; e.sy = e.sx; e.sz = e.sx;
        e.tx = {1'b1, {(CW-1){1'b0}}}; e.ty = e.tx; e.tz = e.tx;
        e.sid = '1; e.rid = '1; e.tick = '1;
        send_edge(e);
        e.sid = '0; e.rid = '0; e.tick = '0;
        send_edge(e);
        set_regs(1'b1, 16'd0, 8'd255, 8'd255);
        e = make_edge(0, 0, 0);       send_edge(e);    // zero distance, zero radius
        e = make_edge(CW'(1), 0, 0);  send_edge(e);
        e = make_edge(0, 0, CW'(-1)); send_edge(e);
        set_regs(1'b1, 16'hFFFF, 8'd7, 8'd0);          // zero cap
        e = make_edge(CW'(-3000000), CW'(3000000), 0); send_edge(e);
        set_regs(1'b1, 16'd10, 8'd200, 8'd3);          // cap below factor
        e = make_edge(CW'(500), 0, 0);  send_edge(e);
        e = make_edge(CW'(15), 0, 0);   send_edge(e);
        set_regs(1'b0, 16'd10, 8'd200, 8'd255);        // throttling off
        e = make_edge(CW'(900), 0, 0);  send_edge(e);
        set_regs(1'b1, 16'd10, 8'd0, 8'd255);          // zero pressure
        e = make_edge(CW'(900), 0, 0);  send_edge(e);
        set_regs(1'b1, 16'hFFFF, 8'd255, 8'd255);
        e = make_edge(CW'(-8000000), CW'(8000000), CW'(8000000)); send_edge(e);
        e = make_edge(CW'(65535), 0, 0); send_edge(e);
        e = make_edge(CW'(65536), 0, 0); send_edge(e);
    endtask

    task automatic test_random_phase(int idle, int stall, int n);
        t_edge e;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        case ($urandom_range(5))
            0: set_regs(1'b1, 16'(1 + $urandom_range(2000)), 8'(1 + $urandom_range(3)),
                        8'($urandom_range(16)));
            1: set_regs(1'b1, 16'($urandom), 8'($urandom), 8'($urandom));
            2: set_regs(1'b1, 16'(1 + $urandom_range(300)), 8'd255, 8'd255);
            3: set_regs(1'b1, 16'd0, 8'd1, 8'd255);
            4: set_regs(1'b0, 16'($urandom), 8'($urandom), 8'($urandom));
            default: set_regs(1'b1, 16'($urandom_range(100)), 8'($urandom_range(1, 80)),
                              8'($urandom_range(1, 255)));
        endcase
        repeat (n) begin
            e = make_edge(band_delta(), band_delta(), band_delta());
            send_edge(e);
        end
    endtask

    initial begin
        errors         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_out_ready    = 1'b0;
        i_sender_x     = '0; i_sender_y = '0; i_sender_z = '0;
        i_target_x     = '0; i_target_y = '0; i_target_z = '0;
        i_sender_id    = '0;
        i_recipient_id = '0;
        i_tick_index   = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = dbrt_pkg::CFG_ENABLE;
        i_cfg_data     = '0;
        thr_enable     = 1'b0;
        thr_near       = dbrt_pkg::NEAR_RESET;
        thr_pressure   = 8'd0;
        thr_max_skip   = 8'(dbrt_pkg::MAX_SKIP_RESET);
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_directed_bands();
        repeat (2) begin
            test_random_phase(0, 0, 120);
            test_random_phase(86, 0, 120);
            test_random_phase(0, 86, 120);
            test_random_phase(15, 15, 120);
        end

        drain();
        if (errors == 0)
            $display("distance_banded_relay_throttle_top regression: pass");
        else
            $display("distance_banded_relay_throttle_top regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
src/dbrt_pkg.sv
src/dbrt_front.sv
src/dbrt_mod_cell.sv
src/distance_banded_relay_throttle_top.sv
tb/distance_banded_relay_throttle_top_tb.sv
